@@ hdl/elal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elal_pkg
// Shared constants, codes and control types of the adjacency list builder.
// ----------------------------------------------------------------------------
package elal_pkg;

  localparam int MAX_NODES   = 16;
  localparam int MAX_DEGREE  = 8;
  localparam int NODE_W      = 4;
  localparam int OP_W        = 2;
  localparam int CFG_W       = 5;
  localparam int DEG_W       = $clog2(MAX_DEGREE + 1);
  localparam int STORE_DEPTH = MAX_NODES * MAX_DEGREE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0] NODE_LIMIT_MAX   = CFG_W'(MAX_NODES);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_LIST  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_U,
    ST_ADD_V,
    ST_LIST_HEAD,
    ST_LIST_RD,
    ST_LIST_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic clear;
    logic set_ovf;
    logic append;
    logic sel_v;
    logic ram_rd;
    logic load_head;
    logic load_entry;
  } cmd_t;

  typedef struct packed {
    logic first_ok;
    logic second_ok;
    logic deg_zero;
    logic entry_last;
    logic slot_free;
  } status_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [NODE_W-1:0] node,
                                                   input logic [DEG_W-1:0] slot);
    store_addr = ADDR_W'(ADDR_W'(node) * ADDR_W'(MAX_DEGREE) + ADDR_W'(slot));
  endfunction

endpackage

@@ hdl/elal_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elal_if
// Channel interfaces: edge and command input, listing output, configuration.
// ----------------------------------------------------------------------------
interface elal_in_if import elal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;

  modport source (output valid, output operation, output first_node,
                  output second_node, input ready);
  modport sink (input valid, input operation, input first_node,
                input second_node, output ready);
endinterface

interface elal_out_if import elal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] listed_node;
  logic [NODE_W-1:0] entry;
  logic              is_head;
  logic              last;
  logic              overflow;

  modport source (output valid, output listed_node, output entry, output is_head,
                  output last, output overflow, input ready);
  modport sink (input valid, input listed_node, input entry, input is_head,
                input last, input overflow, output ready);
endinterface

interface elal_cfg_if import elal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/elal_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module elal_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/elal_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elal_ctrl
// Sequencer for edge appends, list walks and clears.
// ----------------------------------------------------------------------------
module elal_ctrl import elal_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_operation,
  output logic            in_ready,
  input  status_t         status,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (op_t'(in_operation))
            OP_ADD: begin
              if (status.first_ok && status.second_ok) begin
                state_nxt = ST_ADD_U;
              end else begin
                cmd.set_ovf = 1'b1;
              end
            end
            OP_LIST: begin
              if (status.first_ok) begin
                state_nxt = ST_LIST_HEAD;
              end else begin
                cmd.set_ovf = 1'b1;
              end
            end
            OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_U: begin
        cmd.append = 1'b1;
        state_nxt  = ST_ADD_V;
      end
      ST_ADD_V: begin
        cmd.append = 1'b1;
        cmd.sel_v  = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_LIST_HEAD: begin
        if (status.slot_free) begin
          cmd.load_head = 1'b1;
          state_nxt     = status.deg_zero ? ST_IDLE : ST_LIST_RD;
        end
      end
      ST_LIST_RD: begin
        cmd.ram_rd = 1'b1;
        state_nxt  = ST_LIST_OUT;
      end
      ST_LIST_OUT: begin
        if (status.slot_free) begin
          cmd.load_entry = 1'b1;
          state_nxt      = status.entry_last ? ST_IDLE : ST_LIST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/elal_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elal_dp
// Degree counters, neighbour store, overflow flag and output register.
// ----------------------------------------------------------------------------
module elal_dp import elal_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [NODE_W-1:0] in_first,
  input  logic [NODE_W-1:0] in_second,
  elal_cfg_if.sink          cfg_chan,
  elal_out_if.source        out_chan,
  input  cmd_t              cmd,
  output status_t           status
);

  logic [CFG_W-1:0]  node_count_r;
  logic [NODE_W-1:0] u_r, v_r;
  logic [DEG_W-1:0]  k_r;
  logic [DEG_W-1:0]  deg_r [MAX_NODES];
  logic              ovf_r;

  logic              out_valid_r;
  logic [NODE_W-1:0] out_listed_r, out_entry_r;
  logic              out_head_r, out_last_r, out_ovf_r;

  logic [CFG_W-1:0]  node_limit;
  logic [NODE_W-1:0] owner, partner;
  logic [DEG_W-1:0]  deg_cur;
  logic              deg_full;
  logic              do_write;
  logic [NODE_W-1:0] ram_q;

  assign node_limit = (node_count_r < NODE_LIMIT_MAX) ? node_count_r : NODE_LIMIT_MAX;
  assign owner      = cmd.sel_v ? v_r : u_r;
  assign partner    = cmd.sel_v ? u_r : v_r;
  assign deg_cur    = deg_r[owner];
  assign deg_full   = (deg_cur >= DEG_W'(MAX_DEGREE));
  assign do_write   = cmd.append && !deg_full;

  assign status.first_ok   = ({1'b0, in_first} < node_limit);
  assign status.second_ok  = ({1'b0, in_second} < node_limit);
  assign status.deg_zero   = (deg_cur == '0);
  assign status.entry_last = (DEG_W'(k_r + DEG_W'(1)) == deg_cur);
  assign status.slot_free  = !out_valid_r || out_chan.ready;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
    end else if (cfg_chan.valid) begin
      node_count_r <= cfg_chan.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      u_r <= in_first;
      v_r <= in_second;
    end
    if (cmd.load_head) begin
      k_r <= '0;
    end else if (cmd.load_entry) begin
      k_r <= DEG_W'(k_r + DEG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        deg_r[i] <= '0;
      end
    end else if (do_write) begin
      deg_r[owner] <= DEG_W'(deg_cur + DEG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      ovf_r <= 1'b0;
    end else if (cmd.set_ovf || (cmd.append && deg_full)) begin
      ovf_r <= 1'b1;
    end
  end

  elal_ram #(
    .WIDTH (NODE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (store_addr(owner, deg_cur)),
    .wdata (partner),
    .re    (cmd.ram_rd),
    .raddr (store_addr(u_r, k_r)),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_head || cmd.load_entry) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_head) begin
      out_listed_r <= u_r;
      out_entry_r  <= u_r;
      out_head_r   <= 1'b1;
      out_last_r   <= status.deg_zero;
      out_ovf_r    <= ovf_r;
    end else if (cmd.load_entry) begin
      out_listed_r <= u_r;
      out_entry_r  <= ram_q;
      out_head_r   <= 1'b0;
      out_last_r   <= status.entry_last;
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.listed_node = out_listed_r;
  assign out_chan.entry       = out_entry_r;
  assign out_chan.is_head     = out_head_r;
  assign out_chan.last        = out_last_r;
  assign out_chan.overflow    = out_ovf_r;

endmodule

@@ hdl/edge_list_to_adjacency_lists.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_list_to_adjacency_lists
// Builds per-node neighbour lists of an undirected graph from an edge stream.
//
//   Channel    Direction  Payload
//   in_chan    sink       operation, first_node, second_node
//   out_chan   source     listed_node, entry, is_head, last, overflow
//   cfg_chan   sink       data (node_count)
//
// An add is accepted and then makes one store append per endpoint, a clear or
// a dropped item is done when accepted, and a listing emits the head and then,
// through the registered read of the neighbour store, one entry at a time.
// Reset clears the degree counters and the overflow flag.
// A stalled output holds the walk; the next item is taken while the last
// result still waits in the output register.
// ----------------------------------------------------------------------------
module edge_list_to_adjacency_lists import elal_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  elal_in_if.sink    in_chan,
  elal_out_if.source out_chan,
  elal_cfg_if.sink   cfg_chan
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_chan.ready = in_ready;

  elal_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  elal_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_first  (in_chan.first_node),
    .in_second (in_chan.second_node),
    .cfg_chan  (cfg_chan),
    .out_chan  (out_chan),
    .cmd       (cmd),
    .status    (status)
  );

`ifndef SYNTHESIS
  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_head || cmd.load_entry) |-> status.slot_free)
    else $error("output register loaded while occupied");

  a_no_accept_mid_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !(cmd.append || cmd.ram_rd || cmd.load_head || cmd.load_entry))
    else $error("input accepted while an item is in progress");

  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ram_rd |=> !cmd.ram_rd && !in_chan.ready)
    else $error("store read not followed by its output step");

  a_append_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.append && !cmd.sel_v) |=> (cmd.append && cmd.sel_v))
    else $error("first append of an edge not followed by the second");
`endif

endmodule
